/* sv/periodic_event_scheduler_defines.svh */
// ---------------------------------------------------------------------------
// periodic_event_scheduler_defines.svh
// Assertion macros shared by the scheduler's checker.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_EVENT_SCHEDULER_DEFINES_SVH
`define PERIODIC_EVENT_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define PES_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, disabled in reset
`define PES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

/* sv/pes_pkg.sv */
// ---------------------------------------------------------------------------
// pes_pkg
// Types and constants shared by the periodic event scheduler modules.
// ---------------------------------------------------------------------------
package pes_pkg;

  localparam int MAX_JOBS_DEF = 64;

  localparam int ID_W   = 16;
  localparam int PER_W  = 16;
  localparam int TIME_W = 32;

  // Operation codes on in_op
  typedef enum logic {
    OP_REGISTER = 1'b0,
    OP_NEXT     = 1'b1
  } op_t;

  // Result status codes on out_status
  typedef enum logic [1:0] {
    ST_FIRED      = 2'd0,
    ST_REGISTERED = 2'd1,
    ST_FULL       = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  // One job slot as stored in the slot memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PER_W-1:0]  period;
    logic [TIME_W-1:0] next_time;
  } slot_t;

endpackage

/* sv/pes_slot_mem.sv */
// ---------------------------------------------------------------------------
// pes_slot_mem
// Job slot memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module pes_slot_mem #(
  parameter int DEPTH = pes_pkg::MAX_JOBS_DEF,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  pes_pkg::slot_t      wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output pes_pkg::slot_t      rd_data
);

  pes_pkg::slot_t mem [DEPTH];
  pes_pkg::slot_t rd_data_r;

  // Write one slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one slot, data valid the next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/pes_scan.sv */
// ---------------------------------------------------------------------------
// pes_scan
// Shared compare unit: keeps the earliest slot seen during a scan and
// forms its advanced firing time with saturation.
// ---------------------------------------------------------------------------
module pes_scan #(
  parameter int AW = 6
) (
  input  logic                         clk,
  input  logic                         clear,
  input  logic                         cand_vld,
  input  logic [AW-1:0]                cand_idx,
  input  pes_pkg::slot_t               cand,
  output logic [AW-1:0]                best_idx,
  output pes_pkg::slot_t               best,
  output logic [pes_pkg::TIME_W-1:0]   adv_time
);

  logic                        first_r;
  logic [AW-1:0]               best_idx_r;
  pes_pkg::slot_t              best_r;
  logic                        take;
  logic [pes_pkg::TIME_W:0]    sum;

  // Earlier time wins; equal time goes to the lesser id; full tie keeps the lower slot
  assign take = first_r
             || (cand.next_time < best_r.next_time)
             || ((cand.next_time == best_r.next_time) && (cand.id < best_r.id));

  // Hold the running best
  always_ff @(posedge clk) begin
    if (clear) begin
      first_r <= 1'b1;
    end else if (cand_vld) begin
      first_r <= 1'b0;
      if (take) begin
        best_r     <= cand;
        best_idx_r <= cand_idx;
      end
    end
  end

  // Advance by the period, saturate on overflow
  assign sum      = {1'b0, best_r.next_time} + (pes_pkg::TIME_W + 1)'(best_r.period);
  assign adv_time = sum[pes_pkg::TIME_W] ? '1 : sum[pes_pkg::TIME_W-1:0];

  assign best_idx = best_idx_r;
  assign best     = best_r;

endmodule

/* sv/periodic_event_scheduler.sv */
// ---------------------------------------------------------------------------
// periodic_event_scheduler
// Table of periodic jobs; reports the next firing and reschedules it.
// ---------------------------------------------------------------------------
// Usage:
//   Input: drive in_op, in_job_id, in_period with start high; a transaction
//   is taken on a clock edge where start is high and busy is low.
//   Output: exactly one result per input transaction, shown on out_* for
//   one cycle with out_valid high. The receiver cannot stall.
// Timing:
//   Register, table-full and no-jobs results appear in the cycle after the
//   transaction and busy stays low, so these can run every cycle.
//   A fire-next transaction with N jobs stored scans all N slots. The
//   slot memory has one read port, so the scan reads one slot per cycle;
//   then the drain state empties the read pipe and the update state writes
//   back the advanced time. busy is high throughout and the result shows as busy falls.
// Reset:
//   rst_n low empties the table (fill count to zero) and idles the
//   sequencer. Slots fill in order and are never freed, so the fill count
//   alone marks which memory entries hold jobs; no clearing pass runs.
// ---------------------------------------------------------------------------
module periodic_event_scheduler #(
  parameter int MAX_JOBS = pes_pkg::MAX_JOBS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [pes_pkg::ID_W-1:0]      in_job_id,
  input  logic [pes_pkg::PER_W-1:0]     in_period,
  output logic                          out_valid,
  output logic [pes_pkg::ID_W-1:0]      out_fired_id,
  output logic [pes_pkg::TIME_W-1:0]    out_fire_time,
  output logic [1:0]                    out_status
);

  localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [AW-1:0]                 rd_addr_r, rd_addr_nxt;
  logic                          pend_r, pend_nxt;
  logic [AW-1:0]                 pend_idx_r, pend_idx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [pes_pkg::ID_W-1:0]      out_id_r, out_id_nxt;
  logic [pes_pkg::TIME_W-1:0]    out_time_r, out_time_nxt;
  pes_pkg::status_t              out_status_r, out_status_nxt;

  logic                          accept;
  logic                          full;
  logic [CW-1:0]                 count_m1;
  logic [AW-1:0]                 last_addr;
  logic                          scan_clear;

  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  pes_pkg::slot_t                wr_data;
  logic                          rd_en;
  pes_pkg::slot_t                rd_data;

  logic [AW-1:0]                 best_idx;
  pes_pkg::slot_t                best;
  logic [pes_pkg::TIME_W-1:0]    adv_time;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign full      = (count_r == CW'(MAX_JOBS));
  assign count_m1  = count_r - CW'(1);
  assign last_addr = count_m1[AW-1:0];
  assign rd_en     = (state_r == S_SCAN);

  // Sequencer and result register next values
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_addr_nxt    = rd_addr_r;
    pend_nxt       = (state_r == S_SCAN);
    pend_idx_nxt   = rd_addr_r;
    out_valid_nxt  = 1'b0;
    out_id_nxt     = '0;
    out_time_nxt   = '0;
    out_status_nxt = pes_pkg::ST_FIRED;
    wr_en          = 1'b0;
    wr_addr        = count_r[AW-1:0];
    wr_data        = '{id: in_job_id, period: in_period,
                       next_time: pes_pkg::TIME_W'(in_period)};
    scan_clear     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == pes_pkg::OP_REGISTER) begin
            out_valid_nxt = 1'b1;
            if (full) begin
              out_status_nxt = pes_pkg::ST_FULL;
            end else begin
              wr_en          = 1'b1;
              count_nxt      = count_r + CW'(1);
              out_status_nxt = pes_pkg::ST_REGISTERED;
            end
          end else if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pes_pkg::ST_EMPTY;
          end else begin
            scan_clear  = 1'b1;
            rd_addr_nxt = '0;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Issue one slot read per cycle
        if (rd_addr_r == last_addr) begin
          state_nxt = S_DRAIN;
        end else begin
          rd_addr_nxt = rd_addr_r + AW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        // Write back the advanced time and report the firing
        wr_en          = 1'b1;
        wr_addr        = best_idx;
        wr_data        = '{id: best.id, period: best.period, next_time: adv_time};
        out_valid_nxt  = 1'b1;
        out_id_nxt     = best.id;
        out_time_nxt   = best.next_time;
        out_status_nxt = pes_pkg::ST_FIRED;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_addr_r    <= rd_addr_nxt;
    pend_idx_r   <= pend_idx_nxt;
    out_id_r     <= out_id_nxt;
    out_time_r   <= out_time_nxt;
    out_status_r <= out_status_nxt;
  end

  pes_slot_mem #(
    .DEPTH (MAX_JOBS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  pes_scan #(
    .AW (AW)
  ) u_scan (
    .clk      (clk),
    .clear    (scan_clear),
    .cand_vld (pend_r),
    .cand_idx (pend_idx_r),
    .cand     (rd_data),
    .best_idx (best_idx),
    .best     (best),
    .adv_time (adv_time)
  );

  assign out_valid     = out_valid_r;
  assign out_fired_id  = out_id_r;
  assign out_fire_time = out_time_r;
  assign out_status    = out_status_r;

endmodule

/* sv/pes_checker.sv */
// ---------------------------------------------------------------------------
// pes_checker
// Port-level checks on the scheduler's transaction and result timing.
// ---------------------------------------------------------------------------
`include "periodic_event_scheduler_defines.svh"

module pes_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [pes_pkg::ID_W-1:0]      out_fired_id,
  input logic [pes_pkg::TIME_W-1:0]    out_fire_time,
  input logic [1:0]                    out_status
);

  // Every transaction either answers at once or starts a scan
  `PES_ASSERT_NEXT(a_take_answers, clk, rst_n, start && !busy, out_valid || busy)

  // Non-fired results carry zero id and time
  `PES_ASSERT_SAME(a_zero_payload, clk, rst_n, out_valid && (out_status != pes_pkg::ST_FIRED), (out_fired_id == '0) && (out_fire_time == '0))

  // End of a scan always delivers its result
  `PES_ASSERT_SAME(a_scan_done, clk, rst_n, $fell(busy), out_valid && (out_status == pes_pkg::ST_FIRED))

  // A firing only follows a scan
  `PES_ASSERT_SAME(a_fire_after_scan, clk, rst_n, out_valid && (out_status == pes_pkg::ST_FIRED), $past(busy))

endmodule

bind periodic_event_scheduler pes_checker u_pes_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_fired_id  (out_fired_id),
  .out_fire_time (out_fire_time),
  .out_status    (out_status)
);
